### rtl/qrdpc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qrdpc_pkg
// Shared types and constants of the quad-region dark pixel counter.
// ----------------------------------------------------------------------------
package qrdpc_pkg;

  // Default geometry of the pixel coordinates.
  localparam int COORD_BITS_DEF = 12;
  localparam int FRAC_BITS_DEF  = 4;

  // Corner coordinates are 16-bit unsigned fields packed in a 32-bit register.
  localparam int CORNER_BITS = 16;
  localparam int CORNER_REG_W = 2 * CORNER_BITS;
  // Working corner values and line slopes carry one sign bit more.
  localparam int LINE_W = CORNER_BITS + 1;
  // Line offset c = -x0*a - y0*b.
  localparam int OFFS_W = 2 * LINE_W + 1;

  localparam int RATIO_W = 9;
  localparam logic [RATIO_W-1:0] RATIO_ONE = 9'd256;
  localparam int SHRINK_SHIFT = 9;
  localparam int ROUND_HALF = 256;
  // Shrink product: (RATIO_W+1)-bit signed factor times a LINE_W-bit difference.
  localparam int MOVE_PROD_W = LINE_W + RATIO_W + 1;

  localparam int PIX_VAL_W = 8;
  localparam logic [PIX_VAL_W-1:0] DARK_THR_RESET = 8'd100;

  localparam int COUNT_W = 25;
  localparam logic [COUNT_W-1:0] COUNT_LIMIT = 25'd16777216;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = CORNER_REG_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CORNER_UL = 3'd0,
    REG_CORNER_UR = 3'd1,
    REG_CORNER_LR = 3'd2,
    REG_CORNER_LL = 3'd3,
    REG_SHRINK    = 3'd4,
    REG_DARK_THR  = 3'd5
  } reg_idx_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MOVE_MUL,
    S_MOVE_ADD,
    S_LINE_MUL,
    S_LINE_ADD,
    S_EVAL_MUL,
    S_EVAL_SUM,
    S_EMIT
  } ctrl_state_e;

  typedef struct packed {
    logic       load;
    logic       move_mul;
    logic       move_add;
    logic       line_mul;
    logic       line_add;
    logic       eval_mul;
    logic       eval_sum;
    logic       emit;
    logic [1:0] step;
  } dp_cmd_t;

  typedef struct packed {
    logic last;
    logic out_busy;
  } dp_status_t;

endpackage
`default_nettype wire

### rtl/qrdpc_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qrdpc_ctrl
// Sequencer: takes a pixel request, builds the lines when a measurement
// starts, steps the pixel test and hands the result to the output register.
// ----------------------------------------------------------------------------
module qrdpc_ctrl (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   s_valid_i,
  output logic                  s_ready_o,
  input  qrdpc_pkg::dp_status_t sts_i,
  output qrdpc_pkg::dp_cmd_t    cmd_o
);
  import qrdpc_pkg::*;

  ctrl_state_e state_q, state_d;
  logic [1:0]  step_q, step_d;
  logic        lines_ready_q, lines_ready_d;
  logic        accept;

  assign s_ready_o = (state_q == S_IDLE);
  assign accept    = s_ready_o && s_valid_i;

  always_comb begin
    state_d       = state_q;
    step_d        = step_q;
    lines_ready_d = lines_ready_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          step_d  = 2'd0;
          state_d = lines_ready_q ? S_EVAL_MUL : S_MOVE_MUL;
        end
      end
      S_MOVE_MUL: state_d = S_MOVE_ADD;
      S_MOVE_ADD: begin
        step_d  = step_q + 2'd1;
        state_d = (step_q == 2'd3) ? S_LINE_MUL : S_MOVE_MUL;
      end
      S_LINE_MUL: state_d = S_LINE_ADD;
      S_LINE_ADD: begin
        step_d = step_q + 2'd1;
        if (step_q == 2'd3) begin
          lines_ready_d = 1'b1;
          state_d       = S_EVAL_MUL;
        end else begin
          state_d = S_LINE_MUL;
        end
      end
      S_EVAL_MUL: state_d = S_EVAL_SUM;
      S_EVAL_SUM: state_d = sts_i.last ? S_EMIT : S_IDLE;
      S_EMIT: begin
        if (!sts_i.out_busy) begin
          lines_ready_d = 1'b0;
          state_d       = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o          = '0;
    cmd_o.step     = step_q;
    cmd_o.load     = accept;
    cmd_o.move_mul = (state_q == S_MOVE_MUL);
    cmd_o.move_add = (state_q == S_MOVE_ADD);
    cmd_o.line_mul = (state_q == S_LINE_MUL);
    cmd_o.line_add = (state_q == S_LINE_ADD);
    cmd_o.eval_mul = (state_q == S_EVAL_MUL);
    cmd_o.eval_sum = (state_q == S_EVAL_SUM);
    cmd_o.emit     = (state_q == S_EMIT);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      step_q        <= 2'd0;
      lines_ready_q <= 1'b0;
    end else begin
      state_q       <= state_d;
      step_q        <= step_d;
      lines_ready_q <= lines_ready_d;
    end
  end

`ifndef SYNTH
  a_build_on_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !lines_ready_q) |=> (state_q == S_MOVE_MUL))
    else $error("measurement start did not enter the line build");

  a_ready_from_build: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(lines_ready_q) |-> ($past(state_q) == S_LINE_ADD))
    else $error("lines marked ready outside the build sequence");

  a_emit_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT && sts_i.out_busy) |=> (state_q == S_EMIT))
    else $error("result handed over while the output register was full");
`endif

endmodule
`default_nettype wire

### rtl/qrdpc_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qrdpc_datapath
// Corner shrink, line construction, per-pixel half-plane test, saturating
// counters and the result register.
// ----------------------------------------------------------------------------
module qrdpc_datapath #(
  parameter int COORD_BITS = qrdpc_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = qrdpc_pkg::FRAC_BITS_DEF
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  qrdpc_pkg::dp_cmd_t                   cmd_i,
  output qrdpc_pkg::dp_status_t                sts_o,
  input  wire [COORD_BITS-1:0]                 pixel_x_i,
  input  wire [COORD_BITS-1:0]                 pixel_y_i,
  input  wire [qrdpc_pkg::PIX_VAL_W-1:0]       pixel_value_i,
  input  wire                                  last_pixel_i,
  input  wire [qrdpc_pkg::CORNER_REG_W-1:0]    corner_i [4],
  input  wire [qrdpc_pkg::RATIO_W-1:0]         shrink_ratio_i,
  input  wire [qrdpc_pkg::PIX_VAL_W-1:0]       dark_threshold_i,
  output logic                                 out_valid_o,
  input  wire                                  out_ready_i,
  output logic [qrdpc_pkg::COUNT_W-1:0]        dark_count_o,
  output logic [qrdpc_pkg::COUNT_W-1:0]        inside_count_o
);
  import qrdpc_pkg::*;

  localparam int PW    = COORD_BITS + FRAC_BITS;
  localparam int XS_W  = PW + 1;
  localparam int EP_W  = LINE_W + XS_W;
  localparam int S_W   = ((EP_W > OFFS_W) ? EP_W : OFFS_W) + 2;

  // Pixel request.
  logic [COORD_BITS-1:0] pix_x_q, pix_y_q;
  logic [PIX_VAL_W-1:0]  pix_v_q;
  logic                  pix_last_q;

  // Working corners and shrink factor.
  logic signed [LINE_W-1:0] cx_q [4];
  logic signed [LINE_W-1:0] cy_q [4];
  logic [RATIO_W-1:0]       d_q;

  // Move step.
  logic [1:0]                    mv_i;
  logic signed [LINE_W-1:0]      mxi, mxj, myi, myj;
  logic signed [MOVE_PROD_W-1:0] mprod_x_q, mprod_y_q;
  logic signed [MOVE_PROD_W:0]   mt_x, mt_y, msh_x, msh_y;

  // Line step.
  logic signed [LINE_W-1:0]   lxk, lyk, lxn, lyn, la_d, lb_d;
  logic signed [LINE_W-1:0]   la_tmp_q, lb_tmp_q;
  logic signed [2*LINE_W-1:0] pc1_q, pc2_q;
  logic signed [LINE_W-1:0]   la_q [4];
  logic signed [LINE_W-1:0]   lb_q [4];
  logic signed [OFFS_W-1:0]   lc_q [4];

  // Pixel test.
  logic [PW-1:0]          xs_u, ys_u;
  logic signed [XS_W-1:0] xs_s, ys_s;
  logic signed [EP_W-1:0] pa_q [4];
  logic signed [EP_W-1:0] pb_q [4];
  logic signed [S_W-1:0]  sum [4];
  logic [3:0]             outside;
  logic                   in_quad;

  logic [COUNT_W-1:0] inside_total_q, dark_total_q;
  logic               emit_go;

  assign sts_o.last     = pix_last_q;
  assign sts_o.out_busy = out_valid_o && !out_ready_i;
  assign emit_go        = cmd_i.emit && !sts_o.out_busy;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      pix_x_q    <= pixel_x_i;
      pix_y_q    <= pixel_y_i;
      pix_v_q    <= pixel_value_i;
      pix_last_q <= last_pixel_i;
    end
  end

  // Corner 0 moves toward 2, then 2 toward the new 0, then 1 toward 3,
  // then 3 toward the new 1.
  always_comb begin
    case (cmd_i.step)
      2'd0: begin
        mv_i = 2'd0; mxi = cx_q[0]; mxj = cx_q[2]; myi = cy_q[0]; myj = cy_q[2];
      end
      2'd1: begin
        mv_i = 2'd2; mxi = cx_q[2]; mxj = cx_q[0]; myi = cy_q[2]; myj = cy_q[0];
      end
      2'd2: begin
        mv_i = 2'd1; mxi = cx_q[1]; mxj = cx_q[3]; myi = cy_q[1]; myj = cy_q[3];
      end
      default: begin
        mv_i = 2'd3; mxi = cx_q[3]; mxj = cx_q[1]; myi = cy_q[3]; myj = cy_q[1];
      end
    endcase
  end

  // Round half up, then an arithmetic shift gives the floor of the quotient.
  assign mt_x  = (MOVE_PROD_W+1)'(mprod_x_q) + (MOVE_PROD_W+1)'(ROUND_HALF);
  assign mt_y  = (MOVE_PROD_W+1)'(mprod_y_q) + (MOVE_PROD_W+1)'(ROUND_HALF);
  assign msh_x = mt_x >>> SHRINK_SHIFT;
  assign msh_y = mt_y >>> SHRINK_SHIFT;

  // Line k runs from corner k to corner k+1.
  always_comb begin
    case (cmd_i.step)
      2'd0: begin lxk = cx_q[0]; lyk = cy_q[0]; lxn = cx_q[1]; lyn = cy_q[1]; end
      2'd1: begin lxk = cx_q[1]; lyk = cy_q[1]; lxn = cx_q[2]; lyn = cy_q[2]; end
      2'd2: begin lxk = cx_q[2]; lyk = cy_q[2]; lxn = cx_q[3]; lyn = cy_q[3]; end
      default: begin lxk = cx_q[3]; lyk = cy_q[3]; lxn = cx_q[0]; lyn = cy_q[0]; end
    endcase
  end

  assign la_d = lyn - lyk;
  assign lb_d = lxk - lxn;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      for (int k = 0; k < 4; k++) begin
        cx_q[k] <= signed'({1'b0, corner_i[k][CORNER_REG_W-1:CORNER_BITS]});
        cy_q[k] <= signed'({1'b0, corner_i[k][CORNER_BITS-1:0]});
      end
      d_q <= RATIO_ONE - ((shrink_ratio_i > RATIO_ONE) ? RATIO_ONE : shrink_ratio_i);
    end else if (cmd_i.move_add) begin
      cx_q[mv_i] <= mxi + msh_x[LINE_W-1:0];
      cy_q[mv_i] <= myi + msh_y[LINE_W-1:0];
    end
    if (cmd_i.move_mul) begin
      mprod_x_q <= signed'({1'b0, d_q}) * (mxj - mxi);
      mprod_y_q <= signed'({1'b0, d_q}) * (myj - myi);
    end
    if (cmd_i.line_mul) begin
      la_tmp_q <= la_d;
      lb_tmp_q <= lb_d;
      pc1_q    <= lxk * la_d;
      pc2_q    <= lyk * lb_d;
    end
    if (cmd_i.line_add) begin
      la_q[cmd_i.step] <= la_tmp_q;
      lb_q[cmd_i.step] <= lb_tmp_q;
      lc_q[cmd_i.step] <= -OFFS_W'(pc1_q) - OFFS_W'(pc2_q);
    end
  end

  assign xs_u = PW'(pix_x_q) << FRAC_BITS;
  assign ys_u = PW'(pix_y_q) << FRAC_BITS;
  assign xs_s = signed'({1'b0, xs_u});
  assign ys_s = signed'({1'b0, ys_u});

  always_ff @(posedge clk_i) begin
    if (cmd_i.eval_mul) begin
      for (int k = 0; k < 4; k++) begin
        pa_q[k] <= la_q[k] * xs_s;
        pb_q[k] <= lb_q[k] * ys_s;
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      sum[k]     = S_W'(pa_q[k]) + S_W'(pb_q[k]) + S_W'(lc_q[k]);
      outside[k] = !sum[k][S_W-1] && (sum[k] != '0);
    end
  end
  assign in_quad = ~|outside;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inside_total_q <= '0;
      dark_total_q   <= '0;
      out_valid_o    <= 1'b0;
    end else begin
      if (cmd_i.eval_sum && in_quad) begin
        if (inside_total_q < COUNT_LIMIT) begin
          inside_total_q <= inside_total_q + COUNT_W'(1);
        end
        if (pix_v_q > dark_threshold_i && dark_total_q < COUNT_LIMIT) begin
          dark_total_q <= dark_total_q + COUNT_W'(1);
        end
      end else if (emit_go) begin
        inside_total_q <= '0;
        dark_total_q   <= '0;
      end
      if (emit_go) begin
        out_valid_o <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_go) begin
      dark_count_o   <= dark_total_q;
      inside_count_o <= inside_total_q;
    end
  end

`ifndef SYNTH
  a_count_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (inside_total_q <= COUNT_LIMIT) && (dark_total_q <= inside_total_q))
    else $error("counters out of order or past saturation");

  a_clear_on_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_go |=> (inside_total_q == '0 && dark_total_q == '0 && out_valid_o))
    else $error("counters not cleared when the result was loaded");
`endif

endmodule
`default_nettype wire

### rtl/quad_region_dark_pixel_counter_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// quad_region_dark_pixel_counter_top
// Counts pixels inside a shrunken quadrilateral, and the dark ones among them.
// ----------------------------------------------------------------------------
// Each pixel request carries its column, row and gray value; tlast closes a
// measurement. On the first pixel of a measurement, working copies of the
// corners are shrunk by the shrink ratio and the edge lines are built
// in the shared shrink and line units. After that, each pixel is taken in,
// then goes through the eight coefficient multiplies and then through the
// sums, the inside test and the count update; no new pixel is taken until
// that update is done. The last pixel also loads the result register,
// waiting while that register still holds an untaken result. Both counts
// saturate at 2^24. Configuration writes must be made while the block is
// idle; corner and ratio changes take effect at the next measurement.
// ----------------------------------------------------------------------------
module quad_region_dark_pixel_counter_top #(
  parameter int COORD_BITS = qrdpc_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = qrdpc_pkg::FRAC_BITS_DEF,
  localparam int IN_TDATA_W  = ((2 * COORD_BITS + qrdpc_pkg::PIX_VAL_W + 7) / 8) * 8,
  localparam int OUT_TDATA_W = ((2 * qrdpc_pkg::COUNT_W + 7) / 8) * 8
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  // Configuration write port.
  input  wire                              cfg_we_i,
  input  wire [qrdpc_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire [qrdpc_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  // Pixel stream.
  input  wire                              s_axis_tvalid,
  output logic                             s_axis_tready,
  input  wire [IN_TDATA_W-1:0]             s_axis_tdata,  // pixel_x, pixel_y, pixel_value
  input  wire                              s_axis_tlast,
  // Result stream.
  output logic                             m_axis_tvalid,
  input  wire                              m_axis_tready,
  output logic [OUT_TDATA_W-1:0]           m_axis_tdata   // dark_count, inside_count
);
  import qrdpc_pkg::*;

  logic [CORNER_REG_W-1:0] corner_q [4];
  logic [RATIO_W-1:0]      shrink_ratio_q;
  logic [PIX_VAL_W-1:0]    dark_threshold_q;

  dp_cmd_t    cmd;
  dp_status_t sts;

  logic [COUNT_W-1:0] dark_count, inside_count;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 4; k++) begin
        corner_q[k] <= '0;
      end
      shrink_ratio_q   <= RATIO_ONE;
      dark_threshold_q <= DARK_THR_RESET;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_CORNER_UL: corner_q[0] <= cfg_wdata_i;
        REG_CORNER_UR: corner_q[1] <= cfg_wdata_i;
        REG_CORNER_LR: corner_q[2] <= cfg_wdata_i;
        REG_CORNER_LL: corner_q[3] <= cfg_wdata_i;
        REG_SHRINK:    shrink_ratio_q   <= cfg_wdata_i[RATIO_W-1:0];
        REG_DARK_THR:  dark_threshold_q <= cfg_wdata_i[PIX_VAL_W-1:0];
        default: ;
      endcase
    end
  end

  qrdpc_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  qrdpc_datapath #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .pixel_x_i        (s_axis_tdata[COORD_BITS-1:0]),
    .pixel_y_i        (s_axis_tdata[2*COORD_BITS-1:COORD_BITS]),
    .pixel_value_i    (s_axis_tdata[2*COORD_BITS+PIX_VAL_W-1:2*COORD_BITS]),
    .last_pixel_i     (s_axis_tlast),
    .corner_i         (corner_q),
    .shrink_ratio_i   (shrink_ratio_q),
    .dark_threshold_i (dark_threshold_q),
    .out_valid_o      (m_axis_tvalid),
    .out_ready_i      (m_axis_tready),
    .dark_count_o     (dark_count),
    .inside_count_o   (inside_count)
  );

  assign m_axis_tdata = {{(OUT_TDATA_W - 2*COUNT_W){1'b0}}, inside_count, dark_count};

endmodule
`default_nettype wire

### sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the quad-region dark pixel counter.
// ----------------------------------------------------------------------------
// Pixel requests are sent over the input stream and scored against a local
// count model. The model shrinks the programmed corners, builds the edge
// lines on the first pixel of each measurement and tallies inside and dark
// pixels. Directed tests cover the reset defaults, extreme corners and ratios,
// coincident corners, single-pixel measurements and register writes made
// while a measurement is open. Random phases then program a fresh region and
// stream measurements of random length around it, with random source gaps and
// result stalls.
// ----------------------------------------------------------------------------
module tb_top;
  import qrdpc_pkg::*;

  localparam int CBITS         = COORD_BITS_DEF;
  localparam int FBITS         = FRAC_BITS_DEF;
  localparam int IN_W          = 32;
  localparam int OUT_W         = 56;
  localparam int SETTLE_CYCLES = 40;
  localparam int LIMIT_CYCLES  = 400000;
  localparam int RANDOM_ITEMS  = 750;
  localparam int PHASE_ITEMS   = 60;

  typedef struct packed {
    reg_idx_e                idx;
    logic [CFG_DATA_W-1:0]   value;
  } reg_write_t;

  typedef struct packed {
    logic [COUNT_W-1:0] dark;
    logic [COUNT_W-1:0] in_quad;
  } pixel_counts_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  s_valid = 1'b0;
  logic                  s_ready;
  logic [IN_W-1:0]       s_data = '0;  // pixel_x, pixel_y, pixel_value
  logic                  s_last = 1'b0;
  logic                  m_valid;
  logic                  m_ready = 1'b0;
  logic [OUT_W-1:0]      m_data;       // dark_count, inside_count

  // Register copies as the block should hold them.
  logic [31:0] quad_corner [4];
  logic [8:0]  keep_ratio;
  logic [7:0]  dark_thr;

  // Edge lines latched on the first pixel of a measurement, and running counts.
  longint      edge_a [4];
  longint      edge_b [4];
  longint      edge_c [4];
  bit          edges_built = 1'b0;
  int unsigned inside_run = 0;
  int unsigned dark_run = 0;

  pixel_counts_t expected_counts [$];
  reg_write_t    reg_writes [$];
  reg_write_t    cur_write;

  int          src_gap_max = 11;
  int          sink_gap_max = 11;
  int          sink_wait = 0;
  int          sink_draw;
  int          fail_count = 0;
  int unsigned cycle_count = 0;

  // Center and half size of the current random region, in whole pixels.
  int          region_x;
  int          region_y;
  int          region_half;

  quad_region_dark_pixel_counter_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_ready),
    .s_axis_tdata  (s_data),
    .s_axis_tlast  (s_last),
    .m_axis_tvalid (m_valid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_data)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("FAIL");
      $finish;
    end
  end

  // Register writes are queued by the tests and issued one per clock.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_we <= 1'b0;
      for (int k = 0; k < 4; k++) quad_corner[k] = '0;
      keep_ratio = RATIO_ONE;
      dark_thr   = DARK_THR_RESET;
    end else if (reg_writes.size() != 0) begin
      cur_write = reg_writes.pop_front();
      cfg_we    <= 1'b1;
      cfg_idx   <= cur_write.idx;
      cfg_wdata <= cur_write.value;
      case (cur_write.idx)
        REG_SHRINK:   keep_ratio = cur_write.value[RATIO_W-1:0];
        REG_DARK_THR: dark_thr = cur_write.value[PIX_VAL_W-1:0];
        default:      quad_corner[cur_write.idx[1:0]] = cur_write.value;
      endcase
    end else begin
      cfg_we <= 1'b0;
    end
  end

  // Result sink: after each result it draws a stall, counted only while a
  // result is offered. A zero draw keeps tready high.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_ready   <= 1'b0;
      sink_wait <= 0;
    end else if (m_valid && m_ready) begin
      sink_draw = $urandom_range(0, sink_gap_max);
      sink_wait <= sink_draw;
      m_ready   <= (sink_draw == 0);
    end else if (!m_ready) begin
      if (sink_wait == 0) begin
        m_ready <= 1'b1;
      end else if (m_valid) begin
        sink_wait <= sink_wait - 1;
        if (sink_wait == 1) m_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : check_result
    pixel_counts_t want;
    if (rst_ni && m_valid && m_ready) begin
      if (expected_counts.size() == 0) begin
        $error("result with no count pending: %h", m_data);
        fail_count++;
      end else begin
        want = expected_counts.pop_front();
        if (m_data[COUNT_W-1:0] !== want.dark) begin
          $error("dark_count: expected %0d, got %0d", want.dark, m_data[COUNT_W-1:0]);
          fail_count++;
        end
        if (m_data[2*COUNT_W-1:COUNT_W] !== want.in_quad) begin
          $error("inside_count: expected %0d, got %0d", want.in_quad,
                 m_data[2*COUNT_W-1:COUNT_W]);
          fail_count++;
        end
      end
    end
  end

  // Moves one corner coordinate toward another by d/512 of the distance,
  // rounding half up.
  function automatic longint shrink_step(longint src_c, longint dst_c, longint d);
    return src_c + ((d * (dst_c - src_c) + 256) >>> 9);
  endfunction

  function automatic void build_edges();
    longint cx [4];
    longint cy [4];
    longint d;
    int     n;
    d = 256 - ((keep_ratio > RATIO_ONE) ? 256 : int'(keep_ratio));
    for (int k = 0; k < 4; k++) begin
      cx[k] = longint'(quad_corner[k][31:16]);
      cy[k] = longint'(quad_corner[k][15:0]);
    end
    cx[0] = shrink_step(cx[0], cx[2], d);
    cy[0] = shrink_step(cy[0], cy[2], d);
    cx[2] = shrink_step(cx[2], cx[0], d);
    cy[2] = shrink_step(cy[2], cy[0], d);
    cx[1] = shrink_step(cx[1], cx[3], d);
    cy[1] = shrink_step(cy[1], cy[3], d);
    cx[3] = shrink_step(cx[3], cx[1], d);
    cy[3] = shrink_step(cy[3], cy[1], d);
    for (int k = 0; k < 4; k++) begin
      n = (k + 1) % 4;
      edge_a[k] = cy[n] - cy[k];
      edge_b[k] = cx[k] - cx[n];
      edge_c[k] = -(cx[k] * edge_a[k]) - cy[k] * edge_b[k];
    end
    edges_built = 1'b1;
  endfunction

  function automatic void count_pixel(logic [CBITS-1:0] x, logic [CBITS-1:0] y,
                                      logic [7:0] v, logic last);
    longint xs;
    longint ys;
    bit     is_in;
    if (!edges_built) build_edges();
    xs = longint'(x) << FBITS;
    ys = longint'(y) << FBITS;
    is_in = 1'b1;
    for (int k = 0; k < 4; k++)
      if (edge_a[k] * xs + edge_b[k] * ys + edge_c[k] > 0) is_in = 1'b0;
    if (is_in) begin
      if (inside_run < COUNT_LIMIT) inside_run++;
      if (v > dark_thr && dark_run < COUNT_LIMIT) dark_run++;
    end
    if (last) begin
      expected_counts.push_back('{dark: dark_run[COUNT_W-1:0],
                                  in_quad: inside_run[COUNT_W-1:0]});
      inside_run  = 0;
      dark_run    = 0;
      edges_built = 1'b0;
    end
  endfunction

  function automatic int clamp(int v, int hi);
    return (v < 0) ? 0 : ((v > hi) ? hi : v);
  endfunction

  task automatic send_pixel(input logic [CBITS-1:0] x, input logic [CBITS-1:0] y,
                            input logic [7:0] v, input logic last);
    int gap;
    gap = $urandom_range(0, src_gap_max);
    if (gap != 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= {v, y, x};
    s_last  <= last;
    do @(posedge clk_i); while (!s_ready);
    count_pixel(x, y, v, last);
  endtask

  // Waits until every pending count has come back and the block has settled.
  task automatic wait_idle();
    s_valid <= 1'b0;
    while (expected_counts.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [31:0] value);
    reg_writes.push_back('{idx: idx, value: value});
  endtask

  task automatic apply_writes();
    while (reg_writes.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic set_quad(input logic [31:0] ul, input logic [31:0] ur,
                          input logic [31:0] lr, input logic [31:0] ll,
                          input logic [8:0] ratio, input logic [7:0] thr);
    write_reg(REG_CORNER_UL, ul);
    write_reg(REG_CORNER_UR, ur);
    write_reg(REG_CORNER_LR, lr);
    write_reg(REG_CORNER_LL, ll);
    write_reg(REG_SHRINK, 32'(ratio));
    write_reg(REG_DARK_THR, 32'(thr));
    apply_writes();
  endtask

  // With all corners at zero after reset every line is null, so every pixel
  // counts as inside.
  task automatic test_reset_defaults();
    send_pixel(12'd0, 12'd0, 8'd255, 1'b0);
    send_pixel(12'hFFF, 12'hFFF, 8'd0, 1'b0);
    send_pixel(12'hFFF, 12'd0, 8'd101, 1'b0);
    send_pixel(12'd0, 12'hFFF, 8'd100, 1'b1);
    send_pixel(12'd123, 12'd456, 8'd200, 1'b1);
    wait_idle();
  endtask

  task automatic test_extremes();
    set_quad(32'h0000_0000, 32'hFFFF_0000, 32'hFFFF_FFFF, 32'h0000_FFFF, 9'd256, 8'd0);
    send_pixel(12'd0, 12'd0, 8'd0, 1'b0);
    send_pixel(12'hFFF, 12'd0, 8'd255, 1'b0);
    send_pixel(12'hFFF, 12'hFFF, 8'd1, 1'b0);
    send_pixel(12'd0, 12'hFFF, 8'd128, 1'b1);
    wait_idle();
    // Full shrink pulls the corners toward the middle of the frame.
    set_quad(32'h0000_0000, 32'hFFFF_0000, 32'hFFFF_FFFF, 32'h0000_FFFF, 9'd0, 8'd255);
    send_pixel(12'd2048, 12'd2048, 8'd255, 1'b0);
    send_pixel(12'd0, 12'd0, 8'd255, 1'b0);
    send_pixel(12'hFFF, 12'hFFF, 8'd255, 1'b1);
    wait_idle();
    // A ratio above one behaves as no shrink.
    set_quad(32'h0010_0010, 32'hF000_0010, 32'hF000_F000, 32'h0010_F000, 9'h1FF, 8'd100);
    send_pixel(12'd1, 12'd1, 8'd50, 1'b0);
    send_pixel(12'hFFF, 12'd0, 8'd200, 1'b1);
    wait_idle();
    // All corners coincide at the far end of the grid.
    set_quad(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 9'd128, 8'd254);
    send_pixel(12'd17, 12'd4000, 8'd255, 1'b1);
    wait_idle();
    // Two coincident corners; the shrink moves them apart, so no line stays null.
    set_quad(32'h0100_0100, 32'h0100_0100, 32'h0800_0800, 32'h0100_0800, 9'd200, 8'd50);
    send_pixel(12'd32, 12'd64, 8'd60, 1'b0);
    send_pixel(12'd200, 12'd10, 8'd40, 1'b1);
    wait_idle();
  endtask

  // Corner writes made while a measurement is open only apply to the next
  // one; the threshold applies to the pixels that follow.
  task automatic test_late_config();
    set_quad(32'h0100_0100, 32'h0300_0100, 32'h0300_0300, 32'h0100_0300, 9'd256, 8'd100);
    send_pixel(12'd20, 12'd20, 8'd150, 1'b0);
    send_pixel(12'd40, 12'd30, 8'd90, 1'b0);
    wait_idle();
    write_reg(REG_CORNER_UL, 32'h0000_0000);
    write_reg(REG_CORNER_LR, 32'h0000_0000);
    write_reg(REG_DARK_THR, 32'd50);
    apply_writes();
    send_pixel(12'd30, 12'd30, 8'd80, 1'b0);
    send_pixel(12'd100, 12'd100, 8'd255, 1'b1);
    send_pixel(12'd30, 12'd30, 8'd80, 1'b1);
    wait_idle();
  endtask

  task automatic random_region();
    logic [31:0] corner [4];
    logic [8:0]  ratio;
    int          dx;
    int          dy;
    region_x    = $urandom_range(0, 4095);
    region_y    = $urandom_range(0, 4095);
    region_half = ($urandom_range(0, 7) == 0) ? $urandom_range(64, 2048)
                                              : $urandom_range(1, 24);
    for (int k = 0; k < 4; k++) begin
      dx = (k == 1 || k == 2) ? region_half : -region_half;
      dy = (k >= 2) ? region_half : -region_half;
      corner[k][31:16] = 16'(clamp((region_x + dx) * 16 + $urandom_range(0, 32) - 16, 65535));
      corner[k][15:0]  = 16'(clamp((region_y + dy) * 16 + $urandom_range(0, 32) - 16, 65535));
      if ($urandom_range(0, 9) == 0) corner[k] = $urandom();
    end
    case ($urandom_range(0, 4))
      0:       ratio = 9'd0;
      1:       ratio = RATIO_ONE;
      2:       ratio = 9'($urandom_range(257, 511));
      default: ratio = 9'($urandom_range(0, 256));
    endcase
    set_quad(corner[0], corner[1], corner[2], corner[3], ratio, 8'($urandom_range(0, 255)));
  endtask

  task automatic test_random();
    int sent;
    int phase_sent;
    int len;
    int px;
    int py;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      src_gap_max  = $urandom_range(0, 1) ? 11 : 0;
      sink_gap_max = $urandom_range(0, 1) ? 11 : 0;
      random_region();
      phase_sent = 0;
      while (phase_sent < PHASE_ITEMS && sent < RANDOM_ITEMS) begin
        len = ($urandom_range(0, 5) == 0) ? 1 : $urandom_range(2, 16);
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(0, 7) == 0) begin
            px = $urandom_range(0, 4095);
            py = $urandom_range(0, 4095);
          end else begin
            px = clamp(region_x + $urandom_range(0, 2 * region_half + 8) - region_half - 4,
                       4095);
            py = clamp(region_y + $urandom_range(0, 2 * region_half + 8) - region_half - 4,
                       4095);
          end
          send_pixel(12'(px), 12'(py), 8'($urandom_range(0, 255)), i == len - 1);
        end
        phase_sent += len;
        sent += len;
      end
      wait_idle();
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_extremes();
    test_late_config();
    test_random();
    if (fail_count == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

### quad_region_dark_pixel_counter_top.f
rtl/qrdpc_pkg.sv
rtl/qrdpc_ctrl.sv
rtl/qrdpc_datapath.sv
rtl/quad_region_dark_pixel_counter_top.sv
sim/tb_top.sv
